// ===== hw/rtl/lgge_pkg.sv =====
// Shared types and constants of the life grid generation engine.
package lgge_pkg;

    localparam int SIDE_DEFAULT = 64;
    localparam int KIND_W       = 2;
    localparam int COORD_W      = 6;
    localparam int S_DATA_W     = 16;
    localparam int M_DATA_W     = 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_STEP   = 2'd2,
        KIND_READ   = 2'd3
    } kind_t;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_EDIT  = 7'b0000010,
        ST_FETCH = 7'b0000100,
        ST_LOAD  = 7'b0001000,
        ST_CELL  = 7'b0010000,
        ST_WB    = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

endpackage

// ===== hw/rtl/life_grid_generation_engine_core.sv =====
// Top level of the life grid generation engine: grid memory, row window and sequencer.
//
// This block holds a SIDE by SIDE grid of one-bit cells for the B3/S23 rule of
// Conway's Game of Life, every cell dead after reset, with everything outside the
// grid counting as dead. Each input item carries a kind (add a live cell, remove a
// cell, step one generation, read a cell) and a row and column; every item yields
// exactly one result item with the cell value (read only) and a flag that says
// whether a step changed any cell. The grid lives in a memory of SIDE rows of SIDE
// bits with one registered read port and one write port, plus a valid bit per row
// that stands in for the reset clearing. Add and remove take a read-modify-write of
// one row, and read takes a read of one row. A step walks the grid row by row: it
// fetches the next old row into a three-row window (states FETCH and LOAD), then one
// shared neighbour counter and rule unit visits one cell per cycle, and the new row
// is written back in state WB. The block takes one item at a time and is not ready
// while an item is at work. A finished result sits in an output register until it
// is taken.
module life_grid_generation_engine_core
    import lgge_pkg::*;
#(
    parameter int SIDE = SIDE_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    // s_axis_tdata fields from bit 0 up: kind[1:0], row[7:2], col[13:8], zero fill
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // m_axis_tdata fields from bit 0 up: cell_value[0], board_changed[1], zero fill
    output logic [M_DATA_W-1:0] m_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready
);

    localparam int AW = (SIDE > 1) ? $clog2(SIDE) : 1;
    // One bit of headroom so that SIDE itself fits in the on-grid compare.
    localparam int CW = ((AW > COORD_W) ? AW : COORD_W) + 1;

    state_t state_reg, state_next;

    // Command held while the item is at work.
    kind_t          cmd_kind_reg;
    logic [AW-1:0]  cmd_row_reg;
    logic [AW-1:0]  cmd_col_reg;
    logic           cmd_on_grid_reg;

    // Input field decode.
    kind_t          in_kind;
    logic [CW-1:0]  in_row_ext;
    logic [CW-1:0]  in_col_ext;
    logic           in_on_grid;
    logic           s_accept;

    // Grid memory and the per-row valid bits that model the cleared reset state.
    logic [SIDE-1:0] grid_mem [SIDE];
    logic [SIDE-1:0] row_valid_reg;
    logic [SIDE-1:0] rd_data_reg;
    logic            rd_valid_reg;
    logic [SIDE-1:0] row_data;
    logic [AW-1:0]   rd_addr;
    logic            mem_we;
    logic [AW-1:0]   wr_addr;
    logic [SIDE-1:0] wr_data;

    // Step window: old rows above, at and below the row being updated.
    logic [SIDE-1:0] prev_row_reg;
    logic [SIDE-1:0] cur_row_reg;
    logic [SIDE-1:0] next_row_reg;
    logic [SIDE-1:0] new_row_reg;
    logic [AW:0]     fetch_cnt_reg;
    logic [AW-1:0]   row_cnt_reg;
    logic [AW-1:0]   col_cnt_reg;
    logic            primed_reg;

    // Results.
    logic            res_cell_reg;
    logic            res_changed_reg;
    logic            m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    // Shared neighbour count and rule unit.
    logic [AW-1:0]   col_m1;
    logic [AW-1:0]   col_p1;
    logic            has_left;
    logic            has_right;
    logic [3:0]      nb_count;
    logic            alive;
    logic            alive_next;
    logic            fetch_on_grid;
    logic            last_col;
    logic            last_row;

    assign in_kind    = kind_t'(s_axis_tdata[KIND_W-1:0]);
    assign in_row_ext = CW'(s_axis_tdata[KIND_W +: COORD_W]);
    assign in_col_ext = CW'(s_axis_tdata[KIND_W + COORD_W +: COORD_W]);
    assign in_on_grid = (in_row_ext < CW'(SIDE)) && (in_col_ext < CW'(SIDE));

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // A row that was never written since reset reads as all dead.
    assign row_data = rd_valid_reg ? rd_data_reg : '0;

    assign fetch_on_grid = (fetch_cnt_reg < (AW + 1)'(SIDE));
    assign last_col      = (col_cnt_reg == AW'(SIDE - 1));
    assign last_row      = (row_cnt_reg == AW'(SIDE - 1));

    assign col_m1    = col_cnt_reg - 1'b1;
    assign col_p1    = col_cnt_reg + 1'b1;
    assign has_left  = (col_cnt_reg != '0);
    assign has_right = !last_col;

    always_comb begin
        logic [7:0] nb;
        nb[0] = has_left  ? prev_row_reg[col_m1] : 1'b0;
        nb[1] = prev_row_reg[col_cnt_reg];
        nb[2] = has_right ? prev_row_reg[col_p1] : 1'b0;
        nb[3] = has_left  ? cur_row_reg[col_m1]  : 1'b0;
        nb[4] = has_right ? cur_row_reg[col_p1]  : 1'b0;
        nb[5] = has_left  ? next_row_reg[col_m1] : 1'b0;
        nb[6] = next_row_reg[col_cnt_reg];
        nb[7] = has_right ? next_row_reg[col_p1] : 1'b0;
        nb_count = 4'(nb[0]) + 4'(nb[1]) + 4'(nb[2]) + 4'(nb[3])
                 + 4'(nb[4]) + 4'(nb[5]) + 4'(nb[6]) + 4'(nb[7]);
    end

    // B3/S23: a live cell survives on two or three neighbours, a dead one is born on three.
    assign alive      = cur_row_reg[col_cnt_reg];
    assign alive_next = (nb_count == 4'd3) || (alive && (nb_count == 4'd2));

    // Memory port control.
    always_comb begin
        rd_addr = fetch_cnt_reg[AW-1:0];
        mem_we  = 1'b0;
        wr_addr = row_cnt_reg;
        wr_data = new_row_reg;
        if (state_reg == ST_IDLE) begin
            rd_addr = in_row_ext[AW-1:0];
        end
        if (state_reg == ST_EDIT) begin
            wr_addr = cmd_row_reg;
            wr_data = row_data;
            wr_data[cmd_col_reg] = (cmd_kind_reg == KIND_ADD);
            mem_we  = cmd_on_grid_reg &&
                      ((cmd_kind_reg == KIND_ADD) || (cmd_kind_reg == KIND_REMOVE));
        end
        if (state_reg == ST_WB) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            grid_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= grid_mem[rd_addr];
        rd_valid_reg <= row_valid_reg[rd_addr];
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = (in_kind == KIND_STEP) ? ST_FETCH : ST_EDIT;
                end
            end
            ST_EDIT:  state_next = ST_DONE;
            ST_FETCH: state_next = ST_LOAD;
            ST_LOAD:  state_next = primed_reg ? ST_CELL : ST_FETCH;
            ST_CELL: begin
                if (last_col) begin
                    state_next = ST_WB;
                end
            end
            ST_WB:    state_next = last_row ? ST_DONE : ST_FETCH;
            ST_DONE: begin
                if (!m_valid_reg || m_axis_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            row_valid_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (mem_we) begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (state_reg == ST_DONE && (!m_valid_reg || m_axis_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload and datapath registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_kind_reg    <= in_kind;
            cmd_row_reg     <= in_row_ext[AW-1:0];
            cmd_col_reg     <= in_col_ext[AW-1:0];
            cmd_on_grid_reg <= in_on_grid;
            res_cell_reg    <= 1'b0;
            res_changed_reg <= 1'b0;
            prev_row_reg    <= '0;
            cur_row_reg     <= '0;
            next_row_reg    <= '0;
            fetch_cnt_reg   <= '0;
            row_cnt_reg     <= '0;
            col_cnt_reg     <= '0;
            primed_reg      <= 1'b0;
        end
        if (state_reg == ST_EDIT) begin
            res_cell_reg <= cmd_on_grid_reg && (cmd_kind_reg == KIND_READ) &&
                            row_data[cmd_col_reg];
        end
        if (state_reg == ST_LOAD) begin
            prev_row_reg  <= cur_row_reg;
            cur_row_reg   <= next_row_reg;
            next_row_reg  <= fetch_on_grid ? row_data : '0;
            fetch_cnt_reg <= fetch_cnt_reg + 1'b1;
            primed_reg    <= 1'b1;
            col_cnt_reg   <= '0;
        end
        if (state_reg == ST_CELL) begin
            new_row_reg <= {alive_next, new_row_reg[SIDE-1:1]};
            col_cnt_reg <= col_cnt_reg + 1'b1;
            if (alive_next != alive) begin
                res_changed_reg <= 1'b1;
            end
        end
        if (state_reg == ST_WB) begin
            row_cnt_reg <= row_cnt_reg + 1'b1;
        end
        if (state_reg == ST_DONE && (!m_valid_reg || m_axis_tready)) begin
            m_data_reg <= {{(M_DATA_W - 2){1'b0}}, res_changed_reg, res_cell_reg};
        end
    end

endmodule

// ===== tb/life_grid_generation_engine_core_tb.sv =====
// Self-checking testbench for life_grid_generation_engine_core, with its own grid predictor.
`timescale 1ns / 100ps

module life_grid_generation_engine_core_tb
    import lgge_pkg::*;
;

    localparam int SIDE       = SIDE_DEFAULT;
    // Random steps are few, since each one walks the whole grid.
    localparam int STEP_CAP   = 26;
    localparam int RANDOM_CNT = 115;

    // One command item as the sender holds it, with a flag that makes the driver
    // wait until every earlier result has come back before it offers the item.
    typedef struct {
        kind_t            kind;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        bit               wait_for_idle;
    } grid_cmd_t;

    // What the block should answer for one command item.
    typedef struct {
        logic cell_value;
        logic board_changed;
    } grid_answer_t;

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;

    // The predictor's own copy of the board; row index first, column as bit index.
    logic [SIDE-1:0] life_grid [SIDE];

    grid_cmd_t    pending_cmds[$];
    grid_answer_t awaited_answers[$];
    grid_cmd_t    offered_cmd;

    int  error_count = 0;
    int  send_gap    = 0;
    int  hold_left   = 0;
    int  calm_left   = 0;
    int  steps_queued = 0;

    life_grid_generation_engine_core #(
        .SIDE (SIDE)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    always #1 aclk = ~aclk;

    // Works out the next generation of the predictor's board under B3/S23, with
    // every position beyond the edge counted as dead. All cells are judged on the
    // old board, so the update is simultaneous. Returns 1 if any cell changed.
    function automatic logic advance_generation();
        logic [SIDE-1:0] old_grid [SIDE];
        int   live_nbrs;
        int   rr;
        int   cc;
        logic alive;
        logic next_state;
        logic changed;
        old_grid = life_grid;
        changed  = 1'b0;
        for (int r = 0; r < SIDE; r++) begin
            for (int c = 0; c < SIDE; c++) begin
                live_nbrs = 0;
                for (int dr = -1; dr <= 1; dr++) begin
                    for (int dc = -1; dc <= 1; dc++) begin
                        rr = r + dr;
                        cc = c + dc;
                        if ((dr != 0 || dc != 0) && rr >= 0 && rr < SIDE && cc >= 0 && cc < SIDE)
                            live_nbrs += old_grid[rr][cc];
                    end
                end
                alive = old_grid[r][c];
                // A live cell survives on two or three neighbours; a dead cell is born on
                // exactly three and otherwise stays dead.
                next_state = alive ? (live_nbrs == 2 || live_nbrs == 3) : (live_nbrs == 3);
                if (next_state != alive)
                    changed = 1'b1;
                life_grid[r][c] = next_state;
            end
        end
        return changed;
    endfunction

    // Applies one accepted command item to the board and gives the answer it must produce.
    function automatic grid_answer_t apply_grid_cmd(grid_cmd_t cmd);
        grid_answer_t ans;
        ans = '{cell_value: 1'b0, board_changed: 1'b0};
        // Every 6-bit coordinate lies on a 64 by 64 board, so no off-grid case arises.
        case (cmd.kind)
            KIND_ADD:    life_grid[cmd.row][cmd.col] = 1'b1;
            KIND_REMOVE: life_grid[cmd.row][cmd.col] = 1'b0;
            KIND_STEP:   ans.board_changed = advance_generation();
            KIND_READ:   ans.cell_value = life_grid[cmd.row][cmd.col];
            default:     ;
        endcase
        return ans;
    endfunction

    // Idle lengths: mostly none or short, now and then long, and none at all during
    // a calm stretch so that back-to-back traffic is seen as well.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm_left > 0)
            return 0;
        if (roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic queue_cmd(kind_t kind, int row, int col, bit wait_for_idle = 1'b0);
        grid_cmd_t cmd;
        cmd.kind          = kind;
        cmd.row           = row[COORD_W-1:0];
        cmd.col           = col[COORD_W-1:0];
        cmd.wait_for_idle = wait_for_idle;
        if (kind == KIND_STEP)
            steps_queued++;
        pending_cmds.push_back(cmd);
    endtask

    // Calm stretches let the sender run without idling and the result side without long holds.
    always @(posedge aclk) begin
        if (calm_left > 0)
            calm_left <= calm_left - 1;
        else if ($urandom_range(0, 299) == 0)
            calm_left <= $urandom_range(200, 600);
    end

    // Driver: offers the queued command items one at a time. The predictor is run at
    // the edge where an item is accepted, so the expected answers stay in order.
    always @(posedge aclk) begin : drive_cmds
        grid_answer_t ans;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                ans = apply_grid_cmd(offered_cmd);
                awaited_answers.push_back(ans);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap      <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_cmds.size() > 0 &&
                             (!pending_cmds[0].wait_for_idle || awaited_answers.size() == 0)) begin
                    offered_cmd = pending_cmds.pop_front();
                    // tdata from bit 0 up: kind, row, col, then zero fill.
                    s_axis_tdata  <= {2'b00, offered_cmd.col, offered_cmd.row, offered_cmd.kind};
                    s_axis_tvalid <= 1'b1;
                    send_gap      <= pick_gap();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stalls the result channel at random and checks each result item taken
    // against the oldest awaited answer.
    always @(posedge aclk) begin : check_answers
        grid_answer_t want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (awaited_answers.size() == 0) begin
                    $error("result item with no answer awaited, tdata %h", m_axis_tdata);
                    error_count++;
                end else begin
                    want = awaited_answers.pop_front();
                    if (m_axis_tdata[0] !== want.cell_value) begin
                        $error("cell_value: expected %0b, actual %0b",
                               want.cell_value, m_axis_tdata[0]);
                        error_count++;
                    end
                    if (m_axis_tdata[1] !== want.board_changed) begin
                        $error("board_changed: expected %0b, actual %0b",
                               want.board_changed, m_axis_tdata[1]);
                        error_count++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                hold_left     <= pick_gap();
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Stimulus, reset and the end of the run.
    initial begin : run_sequence
        int r0;
        int c0;
        int n_cells;
        int n_steps;
        int queued_random;
        int mode;
        life_grid = '{default: '0};

        // Directed part. An empty board is stagnant; a block in the corner is stable
        // although its neighbours beyond the edge are missing.
        queue_cmd(KIND_READ, 0, 0);
        queue_cmd(KIND_STEP, 0, 0);
        queue_cmd(KIND_ADD, 0, 0);
        queue_cmd(KIND_ADD, 0, 1);
        queue_cmd(KIND_ADD, 1, 0);
        queue_cmd(KIND_ADD, 1, 1);
        queue_cmd(KIND_STEP, 0, 0);
        queue_cmd(KIND_READ, 1, 1);
        // With one corner removed the missing cell has three neighbours and is born again.
        queue_cmd(KIND_REMOVE, 1, 1);
        queue_cmd(KIND_READ, 1, 1);
        queue_cmd(KIND_STEP, 0, 0);
        // A blinker lying on the bottom edge: the cell below it would be off the board,
        // so only the cell above is born and the ends die.
        queue_cmd(KIND_ADD, 63, 61);
        queue_cmd(KIND_ADD, 63, 62);
        queue_cmd(KIND_ADD, 63, 63);
        queue_cmd(KIND_STEP, 0, 0);
        queue_cmd(KIND_READ, 62, 62);
        queue_cmd(KIND_READ, 63, 63);
        // Lone cells in the far corners die of isolation; dead cells never come back stale.
        queue_cmd(KIND_ADD, 0, 63);
        queue_cmd(KIND_ADD, 63, 0);
        queue_cmd(KIND_STEP, 0, 0);
        queue_cmd(KIND_READ, 0, 63);
        queue_cmd(KIND_REMOVE, 62, 62);
        // Alternating coordinate bits so that every row and column bit takes both values.
        queue_cmd(KIND_ADD, 21, 42);
        queue_cmd(KIND_READ, 42, 21);
        queue_cmd(KIND_READ, 21, 42);

        // Random part. Most of it is small clusters followed by steps and reads of the
        // same area, often against an edge; the rest is scattered noise. The first item
        // is held back until every directed result has come.
        queued_random = 0;
        queue_cmd(KIND_READ, 21, 42, 1'b1);
        while (queued_random < RANDOM_CNT) begin
            mode = $urandom_range(0, 9);
            if (mode < 7) begin
                case ($urandom_range(0, 3))
                    0:       r0 = 0;
                    1:       r0 = SIDE - 4;
                    default: r0 = $urandom_range(0, SIDE - 4);
                endcase
                c0 = ($urandom_range(0, 2) == 0) ? (SIDE - 4) * $urandom_range(0, 1)
                                                 : $urandom_range(0, SIDE - 4);
                n_cells = $urandom_range(4, 7);
                for (int i = 0; i < n_cells; i++)
                    queue_cmd(KIND_ADD, r0 + $urandom_range(0, 3), c0 + $urandom_range(0, 3));
                if ($urandom_range(0, 2) == 0) begin
                    queue_cmd(KIND_REMOVE, r0 + $urandom_range(0, 3), c0 + $urandom_range(0, 3));
                    queued_random++;
                end
                n_steps = $urandom_range(1, 2);
                for (int i = 0; i < n_steps; i++)
                    if (steps_queued < STEP_CAP)
                        queue_cmd(KIND_STEP, 0, 0);
                for (int i = 0; i < 3; i++)
                    queue_cmd(KIND_READ, r0 + $urandom_range(0, 4), c0 + $urandom_range(0, 4));
                queued_random += n_cells + 3 + n_steps;
            end else begin
                for (int i = 0; i < 4; i++) begin
                    if ($urandom_range(0, 4) == 0 && steps_queued < STEP_CAP)
                        queue_cmd(KIND_STEP, $urandom_range(0, SIDE - 1), $urandom_range(0, SIDE - 1));
                    else
                        queue_cmd(kind_t'($urandom_range(0, 1) ? KIND_READ : $urandom_range(0, 1)),
                                  $urandom_range(0, SIDE - 1), $urandom_range(0, SIDE - 1));
                end
                queued_random += 4;
            end
            // Now and then the sender waits for the block to drain completely.
            if ($urandom_range(0, 9) == 0)
                pending_cmds[pending_cmds.size() - 1].wait_for_idle = 1'b1;
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for the last item to be taken and every answer to arrive, then give a
        // generous margin for any stray result to show.
        while (pending_cmds.size() != 0)
            @(posedge aclk);
        @(posedge aclk);
        while (s_axis_tvalid || awaited_answers.size() != 0)
            @(posedge aclk);
        repeat (50) @(posedge aclk);

        if (error_count == 0) begin
            $display("[life_grid_generation_engine_core] OK");
        end else begin
            $display("[life_grid_generation_engine_core] ERROR");
        end
        $finish;
    end

    // Watchdog: well beyond the slowest legal run, every item a full step plus the
    // longest idle on each side.
    initial begin : watchdog
        #6_000_000;
        $display("[life_grid_generation_engine_core] ERROR");
        $finish;
    end

endmodule
